>>> hdl/tmp_pkg.sv
package tmp_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int INT_W  = 64;
	localparam int SH_W   = 6;

	localparam logic [1:0] REG_START    = 2'd0;
	localparam logic [1:0] REG_END      = 2'd1;
	localparam logic [1:0] REG_DURATION = 2'd2;

	localparam logic [1:0] PH_ACCEL  = 2'd0;
	localparam logic [1:0] PH_CRUISE = 2'd1;
	localparam logic [1:0] PH_DECEL  = 2'd2;
	localparam logic [1:0] PH_HOLD   = 2'd3;

	// Profile figures derived from the configuration at the intermediate width, plus direction and no-motion flags
	typedef struct packed {
		logic signed [INT_W-1:0] qi;
		logic signed [INT_W-1:0] qf;
		logic [INT_W-1:0]        dur;
		logic [INT_W-1:0]        tc;
		logic [INT_W-1:0]        acc;
		logic [INT_W-1:0]        vc;
		logic                    neg;
		logic                    zero;
	} tmp_prof_t;

endpackage

>>> hdl/trapezoidal_motion_profile_core.sv
// Trapezoidal motion profile in signed fixed point (Q16.16 by default). After reset
// and after every configuration write, busy stays high while a shift-subtract divider
// and a shift-add multiplier derive the profile figures, with no item taken meanwhile.
// Once busy is low, one sample_time item is taken in every cycle that start is high;
// each result appears, in order, with a one-cycle done strobe once its item has passed
// through the pipeline. The receiver cannot stall the block, so a result must be
// captured in the cycle that done is high.
module trapezoidal_motion_profile_core #(
	parameter int DATA_WIDTH = tmp_pkg::DATA_W,
	parameter int FRAC_BITS  = tmp_pkg::FRAC_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_addr,
	input  logic [DATA_WIDTH-1:0]        cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] sample_time,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] position,
	output logic signed [DATA_WIDTH-1:0] velocity,
	output logic signed [DATA_WIDTH-1:0] acceleration,
	output logic [1:0]                   phase,
	output logic                         no_motion,
	output logic                         saturated
);
	import tmp_pkg::*;

	tmp_prof_t prof;

	logic        accept, t_neg;
	logic [63:0] u, tmt, x_c;
	logic [1:0]  ph_c;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [1:0]  ph_s1, ph_s2, ph_s3, ph_s4, ph_s5;
	logic [63:0] x_s1, x_s2, x_s3;
	logic [63:0] sq_s3, pm_s5, vm_s5;
	logic [63:0] pa, pb;
	logic [SH_W-1:0] psh;

	logic [DATA_WIDTH:0] rp, rv, ra;
	logic signed [DATA_WIDTH-1:0] pos_s6, vel_s6, acc_s6;
	logic [1:0] ph_s6;
	logic       nm_s6, sat_s6;

	function automatic logic [DATA_WIDTH:0] sat_add(input logic signed [63:0] base,
		input logic neg, input logic [63:0] mag);
		logic signed [65:0] b, m, s, maxv, minv;
		b    = 66'(base);
		m    = {2'b00, mag};
		s    = neg ? b - m : b + m;
		maxv = $signed(66'((67'd1 << (DATA_WIDTH-1)) - 67'd1));
		minv = ~maxv;
		if (s > maxv) sat_add = {1'b1, maxv[DATA_WIDTH-1:0]};
		else if (s < minv) sat_add = {1'b1, minv[DATA_WIDTH-1:0]};
		else sat_add = {1'b0, s[DATA_WIDTH-1:0]};
	endfunction

	tmp_setup #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_setup (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.busy(busy),
		.prof(prof)
	);

	assign accept = start && !busy;

	// Stage 1: pick the phase and the time offset that drives it
	always_comb begin
		t_neg = sample_time[DATA_WIDTH-1];
		u     = 64'($unsigned(sample_time));
		tmt   = prof.dur - prof.tc;
		ph_c  = PH_HOLD;
		x_c   = '0;
		if (!t_neg) begin
			if (u <= prof.tc) begin
				ph_c = PH_ACCEL;
				x_c  = u;
			end else if (u <= tmt) begin
				ph_c = PH_CRUISE;
				x_c  = u - (prof.tc >> 1);
			end else if (u <= prof.dur) begin
				ph_c = PH_DECEL;
				x_c  = prof.dur - u;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1 <= ph_c;
		x_s1  <= x_c;
		ph_s2 <= ph_s1;
		x_s2  <= x_s1;
		ph_s3 <= ph_s2;
		x_s3  <= x_s2;
		ph_s4 <= ph_s3;
		ph_s5 <= ph_s4;
	end

	// Stages 2-3: square of the offset
	tmp_mul u_sq (
		.clk(clk),
		.a(x_s1),
		.b(x_s1),
		.sh(SH_W'(FRAC_BITS)),
		.p(sq_s3)
	);

	// Cruise takes a linear term, the blends a half square term
	always_comb begin
		if (ph_s3 == PH_CRUISE) begin
			pa  = prof.vc;
			pb  = x_s3;
			psh = SH_W'(FRAC_BITS);
		end else begin
			pa  = prof.acc;
			pb  = sq_s3;
			psh = SH_W'(FRAC_BITS + 1);
		end
	end

	// Stages 4-5: position and velocity magnitudes
	tmp_mul u_pos (
		.clk(clk),
		.a(pa),
		.b(pb),
		.sh(psh),
		.p(pm_s5)
	);

	tmp_mul u_vel (
		.clk(clk),
		.a(prof.acc),
		.b(x_s3),
		.sh(SH_W'(FRAC_BITS)),
		.p(vm_s5)
	);

	// Stage 6: apply direction, clip to range
	always_comb begin
		unique case (ph_s5)
			PH_ACCEL: begin
				rp = sat_add(prof.qi, prof.neg, pm_s5);
				rv = sat_add(64'sd0, prof.neg, vm_s5);
				ra = sat_add(64'sd0, prof.neg, prof.acc);
			end
			PH_CRUISE: begin
				rp = sat_add(prof.qi, prof.neg, pm_s5);
				rv = sat_add(64'sd0, prof.neg, prof.vc);
				ra = '0;
			end
			PH_DECEL: begin
				rp = sat_add(prof.qf, !prof.neg, pm_s5);
				rv = sat_add(64'sd0, prof.neg, vm_s5);
				ra = sat_add(64'sd0, !prof.neg, prof.acc);
			end
			default: begin
				rp = {1'b0, prof.qf[DATA_WIDTH-1:0]};
				rv = '0;
				ra = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (prof.zero) begin
			pos_s6 <= prof.qi[DATA_WIDTH-1:0];
			vel_s6 <= '0;
			acc_s6 <= '0;
			ph_s6  <= PH_HOLD;
			nm_s6  <= 1'b1;
			sat_s6 <= 1'b0;
		end else begin
			pos_s6 <= rp[DATA_WIDTH-1:0];
			vel_s6 <= rv[DATA_WIDTH-1:0];
			acc_s6 <= ra[DATA_WIDTH-1:0];
			ph_s6  <= ph_s5;
			nm_s6  <= 1'b0;
			sat_s6 <= rp[DATA_WIDTH] | rv[DATA_WIDTH] | ra[DATA_WIDTH];
		end
	end

	assign done         = v_s6;
	assign position     = pos_s6;
	assign velocity     = vel_s6;
	assign acceleration = acc_s6;
	assign phase        = ph_s6;
	assign no_motion    = nm_s6;
	assign saturated    = sat_s6;

`ifndef SYNTH
	a_no_entry_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !v_s1)
		else $error("item entered the pipeline while busy");

	a_nm_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && no_motion |-> !saturated && velocity == '0 && acceleration == '0)
		else $error("no-motion result with motion or clipping");

	a_hold_rest: assert property (@(posedge clk) disable iff (!arst_n)
		done && phase == PH_HOLD |-> velocity == '0 && acceleration == '0)
		else $error("hold phase with nonzero rates");
`endif

endmodule

>>> hdl/tmp_mul.sv
module tmp_mul (
	input  logic                       clk,
	input  logic [tmp_pkg::INT_W-1:0]  a,
	input  logic [tmp_pkg::INT_W-1:0]  b,
	input  logic [tmp_pkg::SH_W-1:0]   sh,
	output logic [tmp_pkg::INT_W-1:0]  p
);
	import tmp_pkg::*;

	logic [63:0]     pp_s1 [4];
	logic [SH_W-1:0] sh_s1;
	logic [127:0]    prod;
	logic [127:0]    shifted;
	logic [63:0]     p_s2;

	// Four 32x32 partial products, summed in the next stage
	always_ff @(posedge clk) begin
		pp_s1[0] <= 64'(a[31:0])  * 64'(b[31:0]);
		pp_s1[1] <= 64'(a[31:0])  * 64'(b[63:32]);
		pp_s1[2] <= 64'(a[63:32]) * 64'(b[31:0]);
		pp_s1[3] <= 64'(a[63:32]) * 64'(b[63:32]);
		sh_s1    <= sh;
	end

	always_comb begin
		prod = 128'(pp_s1[0]) + (128'(pp_s1[1]) << 32) + (128'(pp_s1[2]) << 32)
			+ (128'(pp_s1[3]) << 64);
		shifted = prod >> sh_s1;
	end

	// Clip to all ones where the shifted product overflows the intermediate width
	always_ff @(posedge clk) begin
		p_s2 <= (|shifted[127:64]) ? '1 : shifted[63:0];
	end

	assign p = p_s2;

endmodule

>>> hdl/tmp_setup.sv
module tmp_setup #(
	parameter int DATA_WIDTH = tmp_pkg::DATA_W,
	parameter int FRAC_BITS  = tmp_pkg::FRAC_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [DATA_WIDTH-1:0] cfg_data,
	output logic                  busy,
	output tmp_pkg::tmp_prof_t    prof
);
	import tmp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MEAN = 3'd2;
	localparam logic [2:0] ST_VMUL = 3'd3;
	localparam logic [2:0] ST_TC   = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_VC   = 3'd6;

	localparam logic [63:0] KCRUISE = ((64'd101 << FRAC_BITS) + 64'd50) / 64'd100;
	// 2^71/101 rounded up, less its top bit 2^64
	localparam logic [63:0] RECIP_LO = 64'((128'd27 << 64) / 128'd101 + 128'd1);
	localparam logic [6:0]  DIV_SH_STEPS = 7'(64 + FRAC_BITS);
	localparam logic [6:0]  PLAIN_STEPS  = 7'd64;

	logic [DATA_WIDTH-1:0] start_q, end_q;
	logic [DATA_WIDTH-2:0] dur_q;
	logic [2:0]            state_q;
	logic [6:0]            cnt_q, steps_q;
	logic [63:0]           n_q, d_q, rem_q, quo_q, ma_q, mb_q, v_q;
	logic                  ovf_q;
	logic [127:0]          acc_q;
	tmp_prof_t             prof_q;

	logic signed [63:0] qi_w, qf_w;
	logic [63:0]        dur_w, dist_w;
	logic [63:0]        rem_sh, rem_nx, div_res, mul_res, tc_w;
	logic [127:0]       acc_nx, mul_shifted;
	logic               take, op_done;

	always_comb begin
		qi_w   = 64'($signed(start_q));
		qf_w   = 64'($signed(end_q));
		dur_w  = (dur_q == '0) ? 64'd1 : 64'(dur_q);
		dist_w = (qf_w < qi_w) ? 64'(qi_w - qf_w) : 64'(qf_w - qi_w);

		rem_sh  = {rem_q[62:0], n_q[63]};
		take    = rem_q[63] || (rem_sh >= d_q);
		rem_nx  = take ? rem_sh - d_q : rem_sh;
		div_res = (d_q == '0 || ovf_q) ? '1 : quo_q;

		acc_nx      = {acc_q[126:0], 1'b0} + (mb_q[63] ? {64'd0, ma_q} : 128'd0);
		mul_shifted = acc_q >> FRAC_BITS;
		mul_res     = (|mul_shifted[127:64]) ? '1 : mul_shifted[63:0];
		tc_w        = {7'd0, acc_q[127:71]};

		op_done = (cnt_q == steps_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			dur_q   <= (DATA_WIDTH-1)'(64'd1 << FRAC_BITS);
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			steps_q <= '0;
			n_q     <= '0;
			d_q     <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			ma_q    <= '0;
			mb_q    <= '0;
			v_q     <= '0;
			ovf_q   <= 1'b0;
			acc_q   <= '0;
			prof_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START:    start_q <= cfg_data;
				REG_END:      end_q   <= cfg_data;
				REG_DURATION: dur_q   <= cfg_data[DATA_WIDTH-2:0];
				default:      ;
			endcase
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_LOAD: begin
					prof_q.qi   <= qi_w;
					prof_q.qf   <= qf_w;
					prof_q.neg  <= qf_w < qi_w;
					prof_q.zero <= dist_w == '0;
					prof_q.dur  <= dur_w;
					n_q     <= dist_w;
					d_q     <= dur_w;
					rem_q   <= '0;
					quo_q   <= '0;
					ovf_q   <= 1'b0;
					cnt_q   <= '0;
					steps_q <= DIV_SH_STEPS;
					state_q <= ST_MEAN;
				end
				ST_MEAN, ST_ACC: begin
					if (!op_done) begin
						n_q   <= {n_q[62:0], 1'b0};
						rem_q <= rem_nx;
						if (quo_q[63]) ovf_q <= 1'b1;
						quo_q <= {quo_q[62:0], take};
						cnt_q <= cnt_q + 7'd1;
					end else begin
						cnt_q <= '0;
						rem_q <= '0;
						quo_q <= '0;
						ovf_q <= 1'b0;
						acc_q <= '0;
						if (state_q == ST_MEAN) begin
							// mean speed times 1.01
							ma_q    <= div_res;
							mb_q    <= KCRUISE;
							steps_q <= PLAIN_STEPS;
							state_q <= ST_VMUL;
						end else begin
							prof_q.acc <= div_res;
							ma_q    <= div_res;
							mb_q    <= prof_q.tc;
							steps_q <= PLAIN_STEPS;
							state_q <= ST_VC;
						end
					end
				end
				ST_VMUL, ST_TC, ST_VC: begin
					if (!op_done) begin
						acc_q <= acc_nx;
						mb_q  <= {mb_q[62:0], 1'b0};
						cnt_q <= cnt_q + 7'd1;
					end else if (state_q == ST_VMUL) begin
						// blend time: multiply the duration by the reciprocal of 101;
						// seed the sum with the duration for the top bit 2^64
						v_q     <= mul_res;
						ma_q    <= prof_q.dur;
						mb_q    <= RECIP_LO;
						acc_q   <= {64'd0, prof_q.dur};
						cnt_q   <= '0;
						steps_q <= PLAIN_STEPS;
						state_q <= ST_TC;
					end else if (state_q == ST_TC) begin
						prof_q.tc <= tc_w;
						n_q     <= v_q;
						d_q     <= tc_w;
						rem_q   <= '0;
						quo_q   <= '0;
						ovf_q   <= 1'b0;
						cnt_q   <= '0;
						steps_q <= DIV_SH_STEPS;
						state_q <= ST_ACC;
					end else begin
						prof_q.vc <= mul_res;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign prof = prof_q;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import tmp_pkg::*;

	typedef struct packed {
		logic [31:0] position;
		logic [31:0] velocity;
		logic [31:0] acceleration;
		logic [1:0]  phase;
		logic        no_motion;
		logic        saturated;
	} sample_res_t;

	localparam int CYCLE_LIMIT = 600000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_addr;
	logic [DATA_W-1:0]  cfg_data;
	logic               start;
	logic               busy;
	logic signed [31:0] sample_time;
	logic               done;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	logic signed [31:0] acceleration;
	logic [1:0]         phase;
	logic               no_motion;
	logic               saturated;

	logic [31:0] prof_start;
	logic [31:0] prof_end;
	logic [30:0] prof_dur;

	sample_res_t profile_q[$];
	int          errors;
	int          cycles;
	bit          gaps_on;

	trapezoidal_motion_profile_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data), .start(start), .busy(busy), .sample_time(sample_time),
		.done(done), .position(position), .velocity(velocity),
		.acceleration(acceleration), .phase(phase), .no_motion(no_motion),
		.saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> sh;
		return (|p[127:64]) ? '1 : p[63:0];
	endfunction

	function automatic logic [63:0] div_shift(logic [63:0] n, int sh, logic [63:0] d);
		logic [127:0] q;
		if (d == 64'd0)
			return '1;
		q = ({64'd0, n} << sh) / {64'd0, d};
		return (|q[127:64]) ? '1 : q[63:0];
	endfunction

	// {clipped, value}: base plus or minus mag, clipped to 32-bit signed
	function automatic logic [32:0] clip_add(logic signed [63:0] base, bit neg,
		logic [63:0] mag);
		logic signed [66:0] s;
		if (neg)
			s = $signed({{3{base[63]}}, base}) - $signed({3'b000, mag});
		else
			s = $signed({{3{base[63]}}, base}) + $signed({3'b000, mag});
		if (s > 67'sd2147483647)
			return {1'b1, 32'h7fffffff};
		if (s < -67'sd2147483648)
			return {1'b1, 32'h80000000};
		return {1'b0, s[31:0]};
	endfunction

	function automatic sample_res_t predict_sample(logic [31:0] t_in);
		sample_res_t res;
		logic signed [63:0] qi, qf, ts;
		logic [63:0] tdur, span, kc, vmean, tc, am, vc, u, r;
		logic [32:0] p, v, a;
		bit neg;
		qi   = {{32{prof_start[31]}}, prof_start};
		qf   = {{32{prof_end[31]}}, prof_end};
		ts   = {{32{t_in[31]}}, t_in};
		tdur = (prof_dur == 31'd0) ? 64'd1 : {33'd0, prof_dur};
		neg  = qf < qi;
		span = neg ? qi - qf : qf - qi;
		res  = '0;
		res.phase = PH_HOLD;
		if (span == 64'd0) begin
			res.position  = prof_start;
			res.no_motion = 1'b1;
			return res;
		end
		kc    = ((64'd101 << FRAC_W) + 64'd50) / 64'd100;
		vmean = mul_shift(div_shift(span, FRAC_W, tdur), kc, FRAC_W);
		tc    = tdur / 64'd101;
		am    = div_shift(vmean, FRAC_W, tc);
		vc    = mul_shift(am, tc, FRAC_W);
		u     = (ts >= 0) ? ts : 64'd0;
		p     = {1'b0, prof_end};
		v     = '0;
		a     = '0;
		if (ts >= 0 && u <= tc) begin
			res.phase = PH_ACCEL;
			p = clip_add(qi, neg, mul_shift(mul_shift(u, u, FRAC_W), am, FRAC_W + 1));
			v = clip_add(0, neg, mul_shift(am, u, FRAC_W));
			a = clip_add(0, neg, am);
		end else if (ts >= 0 && u <= tdur - tc) begin
			res.phase = PH_CRUISE;
			p = clip_add(qi, neg, mul_shift(vc, u - (tc >> 1), FRAC_W));
			v = clip_add(0, neg, vc);
		end else if (ts >= 0 && u <= tdur) begin
			r = tdur - u;
			res.phase = PH_DECEL;
			p = clip_add(qf, !neg, mul_shift(mul_shift(r, r, FRAC_W), am, FRAC_W + 1));
			v = clip_add(0, neg, mul_shift(am, r, FRAC_W));
			a = clip_add(0, !neg, am);
		end
		res.position     = p[31:0];
		res.velocity     = v[31:0];
		res.acceleration = a[31:0];
		res.saturated    = p[32] | v[32] | a[32];
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycles);
		errors++;
	endtask

	always @(posedge clk) begin
		sample_res_t want;
		if (arst_n && done) begin
			if (profile_q.size() == 0) begin
				report_mismatch("unexpected result", position, 32'd0);
			end else begin
				want = profile_q.pop_front();
				if (position !== want.position)
					report_mismatch("position", position, want.position);
				if (velocity !== want.velocity)
					report_mismatch("velocity", velocity, want.velocity);
				if (acceleration !== want.acceleration)
					report_mismatch("acceleration", acceleration, want.acceleration);
				if (phase !== want.phase)
					report_mismatch("phase", 32'(phase), 32'(want.phase));
				if (no_motion !== want.no_motion)
					report_mismatch("no_motion", 32'(no_motion), 32'(want.no_motion));
				if (saturated !== want.saturated)
					report_mismatch("saturated", 32'(saturated), 32'(want.saturated));
			end
		end
	end

	task automatic wait_ready();
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we   <= 1'b0;
		case (idx)
			REG_START:    prof_start = val;
			REG_END:      prof_end   = val;
			REG_DURATION: prof_dur   = val[30:0];
			default: ;
		endcase
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drain, then program a new profile
	task automatic set_profile(logic [31:0] s_pos, logic [31:0] e_pos, logic [30:0] dur);
		start <= 1'b0;
		@(posedge clk);
		while (profile_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(REG_START, s_pos);
		write_reg(REG_END, e_pos);
		write_reg(REG_DURATION, {1'b0, dur});
	endtask

	task automatic send_sample(logic [31:0] t_in);
		start       <= 1'b1;
		sample_time <= t_in;
		do @(posedge clk); while (busy);
		profile_q.push_back(predict_sample(t_in));
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Sample points around every phase edge of the current profile
	task automatic send_edges();
		logic [31:0] tdur, tc;
		tdur = (prof_dur == 0) ? 32'd1 : {1'b0, prof_dur};
		tc   = tdur / 101;
		send_sample(32'hffffffff);
		send_sample(32'd0);
		send_sample(tc);
		send_sample(tc + 1);
		send_sample(tdur - tc);
		send_sample(tdur - tc + 1);
		send_sample(tdur);
		send_sample(tdur + 1);
	endtask

	task automatic test_no_motion();
		send_sample(32'd0);
		send_sample(32'h7fffffff);
		set_profile(32'h80000000, 32'h80000000, 31'h7fffffff);
		send_sample(32'h80000000);
	endtask

	task automatic test_forward_and_reverse();
		set_profile(32'h0001_0000, 32'h000a_0000, 31'h0004_0000);
		send_edges();
		set_profile(32'h000a_0000, 32'hfff6_0000, 31'h0002_0000);
		send_sample(32'h0001_0000);
		send_sample(32'h0001_f000);
	endtask

	task automatic test_extremes();
		// full-scale travel over a short time saturates
		set_profile(32'h80000000, 32'h7fffffff, 31'd65536);
		send_sample(32'd600);
		send_sample(32'h8000);
		// blend time of zero
		set_profile(32'd0, 32'd100, 31'd1);
		send_sample(32'd0);
		send_sample(32'd1);
		// mean speed truncates to zero
		set_profile(32'd5, 32'd6, 31'h7fffffff);
		send_sample(32'h4000_0000);
		send_sample(32'h7fff_fff0);
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
			default: return $urandom_range(0, 32'h0fff_ffff) - 32'h0800_0000;
		endcase
	endfunction

	task automatic test_random();
		logic [31:0] s_pos, e_pos, tdur, tc, t_in;
		logic [30:0] dur;
		for (int c = 0; c < 12; c++) begin
			s_pos = rand_pos();
			e_pos = ($urandom_range(0, 9) == 0) ? s_pos : rand_pos();
			case ($urandom_range(0, 5))
				0:       dur = 31'($urandom_range(1, 100));
				1:       dur = 31'($urandom);
				default: dur = 31'($urandom_range(32'h0000_1000, 32'h0020_0000));
			endcase
			if (dur == 0) dur = 31'd1;
			set_profile(s_pos, e_pos, dur);
			gaps_on = (c < 10);
			tdur = {1'b0, dur};
			tc   = tdur / 101;
			for (int i = 0; i < 75; i++) begin
				case ($urandom_range(0, 9))
					0:       t_in = $urandom;
					1:       t_in = tc + $urandom_range(0, 4) - 2;
					2:       t_in = tdur - tc + $urandom_range(0, 4) - 2;
					3:       t_in = tdur + $urandom_range(0, 4) - 2;
					4:       t_in = $urandom_range(0, 4) - 2;
					default: t_in = $urandom_range(0, tdur);
				endcase
				send_sample(t_in);
			end
		end
		start <= 1'b0;
	endtask

	initial begin
		gaps_on     = 1'b1;
		prof_start  = 32'd0;
		prof_end    = 32'd0;
		prof_dur    = 31'd65536;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_addr    = REG_START;
		cfg_data    = '0;
		start       = 1'b0;
		sample_time = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait_ready();
		test_no_motion();
		test_forward_and_reverse();
		test_extremes();
		test_random();
		@(posedge clk);
		while (profile_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> trapezoidal_motion_profile_core.f
hdl/tmp_pkg.sv
hdl/tmp_mul.sv
hdl/tmp_setup.sv
hdl/trapezoidal_motion_profile_core.sv
verif/tb.sv
